/* sv/scba_pkg.sv */
// ----------------------------------------------------------------------------
// scba_pkg: shared types and constants of the size class bump allocator
// Field widths, status and register index codes, default parameters and the
// command bundle from the controller to the datapath.
// ----------------------------------------------------------------------------
package scba_pkg;

   // fixed field widths
   localparam int REQ_W      = 16;
   localparam int OUT_ADDR_W = 32;
   localparam int HSIZE_W    = 11;
   localparam int STATUS_W   = 2;
   localparam int CSR_W      = 32;
   localparam int CSR_IDX_W  = 2;

   // largest request that a class can serve
   localparam int SIZE_LIMIT = 1024;
   // bits of (size - 1) for sizes up to the limit
   localparam int SIZE_M1_W  = 10;
   // reciprocal shift for the divide by the granule
   localparam int DIV_SHIFT  = 20;

   localparam logic [CSR_W-1:0] HEAP_SIZE_RESET = 32'd16384;

   // default parameter values
   localparam int DEF_NUM_CLASSES      = 64;
   localparam int DEF_GRANULE_BYTES    = 16;
   localparam int DEF_HEADER_BYTES     = 16;
   localparam int DEF_CHUNKS_PER_BLOCK = 10;
   localparam int DEF_ADDR_WIDTH       = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_BASE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_SIZE = 2'd1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_GRANTED   = 2'd0,
      STATUS_TOO_LARGE = 2'd1,
      STATUS_EXHAUSTED = 2'd2
   } status_type;

   // capture: take the request word and launch the table read
   // commit:  resolve the request, update state, load the result word
   typedef struct packed {
      logic capture;
      logic commit;
   } scba_cmd_type;

endpackage

/* sv/scba_ctrl.sv */
// ----------------------------------------------------------------------------
// scba_ctrl: request sequencer
// Two-state controller: take a request word, then commit it once the result
// register is free.
// ----------------------------------------------------------------------------
module scba_ctrl import scba_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output scba_cmd_type cmd
);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd.capture  = (state_ff == S_IDLE) && req_valid;
      cmd.commit   = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            // hold while the result register is still occupied
            if (cmd.commit) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* sv/scba_dp.sv */
// ----------------------------------------------------------------------------
// scba_dp: allocator datapath
// Class lookup, per-class pointer table, heap offset, config registers and
// the result register.
// ----------------------------------------------------------------------------
module scba_dp import scba_pkg::*; #(
   parameter int NUM_CLASSES      = DEF_NUM_CLASSES,
   parameter int GRANULE_BYTES    = DEF_GRANULE_BYTES,
   parameter int HEADER_BYTES     = DEF_HEADER_BYTES,
   parameter int CHUNKS_PER_BLOCK = DEF_CHUNKS_PER_BLOCK,
   parameter int ADDR_WIDTH       = DEF_ADDR_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  scba_cmd_type          cmd,
   input  logic [REQ_W-1:0]      req_request_size,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_write_data,
   output logic [OUT_ADDR_W-1:0] rsp_payload_address,
   output logic [HSIZE_W-1:0]    rsp_header_size,
   output logic [STATUS_W-1:0]   rsp_status
);

   localparam int CLS_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int CLASS_W = $clog2(SIZE_LIMIT + GRANULE_BYTES + 1);
   localparam int CHUNK_W = $clog2(SIZE_LIMIT + GRANULE_BYTES + HEADER_BYTES + 1);
   localparam int BLOCK_W =
      $clog2((SIZE_LIMIT + GRANULE_BYTES + HEADER_BYTES) * CHUNKS_PER_BLOCK + 1);
   localparam int PROD_W  = DIV_SHIFT + SIZE_M1_W;
   localparam int RECIP   = (2 ** DIV_SHIFT + GRANULE_BYTES - 1) / GRANULE_BYTES;

   typedef struct packed {
      logic [ADDR_WIDTH-1:0] next_addr;
      logic [ADDR_WIDTH-1:0] end_addr;
   } entry_type;

   // configuration
   logic [CSR_W-1:0] heap_base_ff, heap_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff <= '0;
         heap_size_ff <= HEAP_SIZE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_HEAP_BASE: heap_base_ff <= csr_write_data;
            CSR_HEAP_SIZE: heap_size_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // class lookup: (size - 1) / granule by reciprocal multiply
   logic [REQ_W-1:0]     size_m1_full;
   logic [SIZE_M1_W-1:0] size_m1;
   logic [PROD_W-1:0]    quot_prod;
   logic [SIZE_M1_W-1:0] quot;
   logic                 too_large_in;
   logic [CLS_W-1:0]     cls_in;

   always_comb begin
      size_m1_full = req_request_size - REQ_W'(1);
      size_m1      = size_m1_full[SIZE_M1_W-1:0];
      quot_prod    = PROD_W'(size_m1) * PROD_W'(RECIP);
      quot         = (req_request_size == '0) ? '0 : quot_prod[PROD_W-1:DIV_SHIFT];
      too_large_in = (req_request_size > REQ_W'(SIZE_LIMIT)) ||
                     ({1'b0, quot} >= (SIZE_M1_W + 1)'(NUM_CLASSES));
      cls_in       = quot[CLS_W-1:0];
   end

   // pointer table and per-class active bits
   entry_type             table_mem [NUM_CLASSES];
   entry_type             rd_entry_ff;
   logic [CLS_W-1:0]      cls_ff;
   logic                  too_large_ff;
   logic [NUM_CLASSES-1:0] active_ff;
   logic [CSR_W-1:0]      heap_used_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_entry_ff  <= table_mem[cls_in];
         cls_ff       <= cls_in;
         too_large_ff <= too_large_in;
      end
   end

   // resolve the request
   logic [CLASS_W-1:0]    class_bytes;
   logic [CHUNK_W-1:0]    chunk_bytes;
   logic [BLOCK_W-1:0]    block_bytes;
   logic [ADDR_WIDTH-1:0] chunk_ext, block_ext, room, base_addr;
   logic [ADDR_WIDTH-1:0] chunk_start, next_in, end_in, payload_addr;
   logic [63:0]           base_sum, payload_wide;
   logic [CSR_W:0]        heap_sum;
   logic                  need_carve, heap_fail, granted;
   status_type            status_in;

   always_comb begin
      class_bytes = CLASS_W'(GRANULE_BYTES) * (CLASS_W'(cls_ff) + CLASS_W'(1));
      chunk_bytes = CHUNK_W'(class_bytes) + CHUNK_W'(HEADER_BYTES);
      block_bytes = BLOCK_W'(chunk_bytes) * BLOCK_W'(CHUNKS_PER_BLOCK);
      chunk_ext   = ADDR_WIDTH'(chunk_bytes);
      block_ext   = ADDR_WIDTH'(block_bytes);
      room        = rd_entry_ff.end_addr - rd_entry_ff.next_addr;
      need_carve  = !active_ff[cls_ff] || (room < chunk_ext);
      heap_sum    = {1'b0, heap_used_ff} + (CSR_W + 1)'(block_bytes);
      heap_fail   = heap_sum > {1'b0, heap_size_ff};
      base_sum    = 64'(heap_base_ff) + 64'(heap_used_ff);
      base_addr   = base_sum[ADDR_WIDTH-1:0];
      chunk_start = need_carve ? base_addr : rd_entry_ff.next_addr;
      end_in      = need_carve ? (base_addr + block_ext) : rd_entry_ff.end_addr;
      next_in     = chunk_start + chunk_ext;
      payload_addr = chunk_start + ADDR_WIDTH'(HEADER_BYTES);
      payload_wide = 64'(payload_addr);
      if (too_large_ff) begin
         status_in = STATUS_TOO_LARGE;
      end else if (need_carve && heap_fail) begin
         status_in = STATUS_EXHAUSTED;
      end else begin
         status_in = STATUS_GRANTED;
      end
      granted = (status_in == STATUS_GRANTED);
   end

   // state update on commit; failed requests leave everything unchanged
   always_ff @(posedge clock) begin
      if (cmd.commit && granted) begin
         table_mem[cls_ff] <= '{next_addr: next_in, end_addr: end_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         heap_used_ff <= '0;
      end else if (cmd.commit && granted && need_carve) begin
         active_ff[cls_ff] <= 1'b1;
         heap_used_ff      <= heap_sum[CSR_W-1:0];
      end
   end

   // result register
   logic [OUT_ADDR_W-1:0] addr_ff;
   logic [HSIZE_W-1:0]    hsize_ff;
   status_type            status_ff;

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         addr_ff   <= granted ? payload_wide[OUT_ADDR_W-1:0] : '0;
         hsize_ff  <= granted ? HSIZE_W'(class_bytes) : '0;
         status_ff <= status_in;
      end
   end

   assign rsp_payload_address = addr_ff;
   assign rsp_header_size     = hsize_ff;
   assign rsp_status          = status_ff;

endmodule

/* sv/size_class_bump_allocator.sv */
// ----------------------------------------------------------------------------
// size_class_bump_allocator: segregated size class bump allocator
// Hands out heap chunks from per-class blocks carved off a global heap offset.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one request word (req_request_size, bytes). Sizes up to
//    1024 map to classes GRANULE_BYTES apart; larger sizes return status 1.
//  - rsp_* returns one word per request: payload address (chunk start plus
//    the header), class size for the chunk header, and status (0 granted,
//    1 too large, 2 heap exhausted; address and size zero on failure).
//  - csr_* writes heap_base (index 0) and heap_size (index 1) while idle;
//    other indexes are dropped. heap_base affects only later carves.
//  - Timing: the accept edge launches the registered read of the class
//    pointer table; the commit, which waits while the result register is
//    still full, resolves the request, writes the table and heap offset, and
//    loads the result register. The next request is accepted only after
//    this commit, as set by the table read-modify-write.
//  - A waiting result does not block the next accept; if the result register
//    is still full when the next request resolves, hold it until rsp_ready.
//  - Reset clears all class active bits, the heap offset, and sets
//    heap_base to 0 and heap_size to 16384. No clearing pass is needed.
// ----------------------------------------------------------------------------
module size_class_bump_allocator import scba_pkg::*; #(
   parameter int NUM_CLASSES      = DEF_NUM_CLASSES,
   parameter int GRANULE_BYTES    = DEF_GRANULE_BYTES,
   parameter int HEADER_BYTES     = DEF_HEADER_BYTES,
   parameter int CHUNKS_PER_BLOCK = DEF_CHUNKS_PER_BLOCK,
   parameter int ADDR_WIDTH       = DEF_ADDR_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [REQ_W-1:0]      req_request_size,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [OUT_ADDR_W-1:0] rsp_payload_address,
   output logic [HSIZE_W-1:0]    rsp_header_size,
   output logic [STATUS_W-1:0]   rsp_status,
   // configuration write port
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_write_data
);

   scba_cmd_type cmd;

   // sequencer: idle/accept, then commit when the result register frees up
   scba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // class lookup, pointer table, heap offset and result register
   scba_dp #(
      .NUM_CLASSES      (NUM_CLASSES),
      .GRANULE_BYTES    (GRANULE_BYTES),
      .HEADER_BYTES     (HEADER_BYTES),
      .CHUNKS_PER_BLOCK (CHUNKS_PER_BLOCK),
      .ADDR_WIDTH       (ADDR_WIDTH)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_request_size    (req_request_size),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .rsp_payload_address (rsp_payload_address),
      .rsp_header_size     (rsp_header_size),
      .rsp_status          (rsp_status)
   );

endmodule

/* dv/scba_grant_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scba_grant_checker: grant predictor and result checker
// Watches the request, result and register ports of the allocator, predicts
// every result word and compares it field by field.
// ----------------------------------------------------------------------------
module scba_grant_checker import scba_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [REQ_W-1:0]      req_request_size,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [OUT_ADDR_W-1:0] rsp_payload_address,
   input  logic [HSIZE_W-1:0]    rsp_header_size,
   input  logic [STATUS_W-1:0]   rsp_status,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_write_data,
   output int                    outstanding,
   output int                    mismatches
);

   typedef struct packed {
      logic [OUT_ADDR_W-1:0] address;
      logic [HSIZE_W-1:0]    class_size;
      status_type            status;
   } grant_type;

   logic [CSR_W-1:0]          heap_base;
   logic [CSR_W-1:0]          heap_size;
   logic [CSR_W-1:0]          heap_used;
   logic                      class_live [DEF_NUM_CLASSES];
   logic [DEF_ADDR_WIDTH-1:0] class_next [DEF_NUM_CLASSES];
   logic [DEF_ADDR_WIDTH-1:0] class_end  [DEF_NUM_CLASSES];
   grant_type                 awaited_grants [$];
   int                        fail_count = 0;

   // Resolve one request against the shadow tables and advance them.
   function automatic grant_type predict_grant(input logic [REQ_W-1:0] size);
      grant_type                 g;
      int unsigned               cls;
      int unsigned               class_bytes;
      int unsigned               chunk_bytes;
      int unsigned               block_bytes;
      logic [DEF_ADDR_WIDTH-1:0] room;
      logic [DEF_ADDR_WIDTH-1:0] chunk;
      logic [63:0]               heap_need;
      g = '0;
      if (size > SIZE_LIMIT) begin
         g.status = STATUS_TOO_LARGE;
         return g;
      end
      cls = (size <= DEF_GRANULE_BYTES) ? 0 : (size - 1) / DEF_GRANULE_BYTES;
      if (cls >= DEF_NUM_CLASSES) begin
         g.status = STATUS_TOO_LARGE;
         return g;
      end
      class_bytes = DEF_GRANULE_BYTES * (cls + 1);
      chunk_bytes = class_bytes + DEF_HEADER_BYTES;
      block_bytes = chunk_bytes * DEF_CHUNKS_PER_BLOCK;
      room = class_end[cls] - class_next[cls];
      if (!class_live[cls] || room < chunk_bytes) begin
         // carve a fresh block; leftover room in the old one is abandoned
         heap_need = {32'd0, heap_used} + 64'(block_bytes);
         if (heap_need > {32'd0, heap_size}) begin
            g.status = STATUS_EXHAUSTED;
            return g;
         end
         class_next[cls] = heap_base + heap_used;
         class_end[cls]  = heap_base + heap_used + block_bytes;
         heap_used       = heap_used + block_bytes;
         class_live[cls] = 1'b1;
      end
      chunk           = class_next[cls];
      class_next[cls] = chunk + chunk_bytes;
      g.address       = chunk + DEF_HEADER_BYTES;
      g.class_size    = HSIZE_W'(class_bytes);
      g.status        = STATUS_GRANTED;
      return g;
   endfunction

   always @(posedge clock) begin
      grant_type want;
      if (reset) begin
         heap_base = '0;
         heap_size = HEAP_SIZE_RESET;
         heap_used = '0;
         foreach (class_live[i]) class_live[i] = 1'b0;
         awaited_grants.delete();
      end else begin
         // results first, so a word accepted on this edge is never matched here
         if (rsp_valid && rsp_ready) begin
            if (awaited_grants.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: result word with none expected: addr %h size %0d status %0d",
                           $realtime, rsp_payload_address, rsp_header_size, rsp_status);
            end else begin
               want = awaited_grants.pop_front();
               if (rsp_payload_address !== want.address ||
                   rsp_header_size !== want.class_size || rsp_status !== want.status) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: grant mismatch: expected %h/%0d/%0d, got %h/%0d/%0d",
                              $realtime, want.address, want.class_size, want.status,
                              rsp_payload_address, rsp_header_size, rsp_status);
               end
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_HEAP_BASE: heap_base = csr_write_data;
               CSR_HEAP_SIZE: heap_size = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            awaited_grants.push_back(predict_grant(req_request_size));
      end
      outstanding <= awaited_grants.size();
      mismatches  <= fail_count;
   end

endmodule

/* dv/size_class_bump_allocator_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_class_bump_allocator_test: request stimulus and verdict
// Drives a directed opening and seven random phases with their own heap settings into the
// allocator under bursty requests and a stalling receiver; the grant checker
// beside it predicts and compares every result word.
// ----------------------------------------------------------------------------
module size_class_bump_allocator_test import scba_pkg::*;;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASES       = 7;
   localparam int PHASE_ITEMS  = 250;
   localparam int SETTLE_DELAY = 4;
   // index with no register behind it; writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_ONE_IN_FOUR,
      READY_MOSTLY
   } ready_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [REQ_W-1:0]      req_request_size = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [OUT_ADDR_W-1:0] rsp_payload_address;
   logic [HSIZE_W-1:0]    rsp_header_size;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_W-1:0]      csr_write_data = '0;

   int             outstanding;
   int             mismatches;
   int             cycle_count = 0;
   int             burst_left = 0;
   int unsigned    hot_class [4];
   ready_mode_type ready_mode = READY_ALWAYS;
   int             ready_hold = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   size_class_bump_allocator uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_request_size    (req_request_size),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_payload_address (rsp_payload_address),
      .rsp_header_size     (rsp_header_size),
      .rsp_status          (rsp_status),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   scba_grant_checker grant_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_request_size    (req_request_size),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_payload_address (rsp_payload_address),
      .rsp_header_size     (rsp_header_size),
      .rsp_status          (rsp_status),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .outstanding         (outstanding),
      .mismatches          (mismatches)
   );

   // Receiver: switch between stall styles at random, so that back pressure
   // meets the block at each point of its read-modify-write and some
   // stretches see none at all.
   always @(posedge clock) begin
      if (ready_hold == 0) begin
         ready_mode <= ready_mode_type'($urandom_range(0, 3));
         ready_hold <= $urandom_range(50, 300);
      end else begin
         ready_hold <= ready_hold - 1;
      end
      case (ready_mode)
         READY_ALWAYS:      rsp_ready <= 1'b1;
         READY_COIN:        rsp_ready <= 1'($urandom_range(0, 1));
         READY_ONE_IN_FOUR: rsp_ready <= (ready_hold % 4 == 0);
         default:           rsp_ready <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // Hang guard: count cycles and give up well past the slowest honest run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   // Send one request word. Between bursts, drop valid for a random gap;
   // within a burst, hold valid and load the next word on the accept edge.
   task automatic send_size(input logic [REQ_W-1:0] size);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
      req_valid        <= 1'b1;
      req_request_size <= size;
      do @(posedge clock); while (!req_ready);
      burst_left--;
   endtask

   // Stop sending and wait until every predicted word has come back.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_DELAY) @(posedge clock);
   endtask

   // Write both heap registers, then poke the unused index, which must be
   // ignored. Enable stays high across the three writes.
   task automatic program_heap(input logic [CSR_W-1:0] base, input logic [CSR_W-1:0] limit);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_HEAP_BASE;
      csr_write_data   <= base;
      @(posedge clock);
      csr_index        <= CSR_HEAP_SIZE;
      csr_write_data   <= limit;
      @(posedge clock);
      csr_index        <= CSR_SPARE;
      csr_write_data   <= $urandom();
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Mostly sizes from a few hot classes, so blocks fill up and get re-carved;
   // the rest spread over all classes, oversize words and the boundaries.
   function automatic logic [REQ_W-1:0] pick_size();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return REQ_W'(hot_class[$urandom_range(0, 3)] * DEF_GRANULE_BYTES +
                       $urandom_range(1, DEF_GRANULE_BYTES));
      if (roll < 85)
         return REQ_W'($urandom_range(0, SIZE_LIMIT));
      if (roll < 95)
         return REQ_W'($urandom_range(SIZE_LIMIT + 1, 65535));
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return REQ_W'(SIZE_LIMIT);
         2:       return REQ_W'(SIZE_LIMIT + 1);
         default: return '1;
      endcase
   endfunction

   initial begin
      logic [REQ_W-1:0] opening_sizes [20];
      logic [CSR_W-1:0] base;
      logic [CSR_W-1:0] limit;
      int               phase;
      int               n;

      // Opening against the reset heap of 16 KiB:
      //  - size zero and the edges of the smallest class
      //  - the largest class, then oversize words up to the top of the field
      //  - eight more smallest-class words: the last one finds its block
      //    used up and carves another
      //  - sizes 1008, 1008 and 512 no longer fit, so the heap reports exhausted
      //  - a smallest-class word still served from the block that has room
      opening_sizes = '{16'd0, 16'd1, 16'd16, 16'd17, 16'd1024, 16'd1025, 16'd65535,
                        16'd32768, 16'd8, 16'd8, 16'd8, 16'd8, 16'd8, 16'd8, 16'd8,
                        16'd8, 16'd1008, 16'd1008, 16'd512, 16'd2};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (opening_sizes[i]) send_size(opening_sizes[i]);
      settle();

      // Random phases, each under its own heap setting. The block is idle
      // whenever the registers change.
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin  // reset values; what is left of the heap runs out here
               base  = '0;
               limit = HEAP_SIZE_RESET;
            end
            1: begin  // empty heap: only blocks with room left can grant
               base  = $urandom();
               limit = '0;
            end
            2: begin  // base just below the top, so chunk addresses wrap
               base  = 32'hFFFF_F000;
               limit = '1;
            end
            3: begin
               base  = '1;
               limit = '1;
            end
            4: begin
               base  = $urandom();
               limit = $urandom();
            end
            5: begin  // small limit, likely below what is already carved
               base  = $urandom();
               limit = $urandom_range(0, 32'h0040_0000);
            end
            default: begin
               base  = $urandom();
               limit = '1;
            end
         endcase
         program_heap(base, limit);

         // favor small classes so the heap lasts and blocks turn over often
         foreach (hot_class[i])
            hot_class[i] = $urandom_range(0, 1) ? $urandom_range(0, 7)
                                                : $urandom_range(0, DEF_NUM_CLASSES - 1);

         for (n = 0; n < PHASE_ITEMS; n++) begin
            // now and then drain completely before going on
            if ($urandom_range(0, 199) == 0) settle();
            send_size(pick_size());
         end
         settle();
      end

      if (mismatches == 0 && outstanding == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
